### hw/rtl/espr_pkg.sv
package espr_pkg;

   localparam int CFG_W = 16;
   localparam int CFG_IDX_W = 3;

   localparam logic [2:0] OP_TICK = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP = 3'd2;
   localparam logic [2:0] OP_SET_LEVEL = 3'd3;
   localparam logic [2:0] OP_WARN_SLOW = 3'd4;
   localparam logic [2:0] OP_WARN_RECOVER = 3'd5;

   localparam logic [1:0] LVL_STOP = 2'd0;
   localparam logic [1:0] LVL_SLOW = 2'd1;
   localparam logic [1:0] LVL_MID = 2'd2;
   localparam logic [1:0] LVL_FAST = 2'd3;

   localparam logic [2:0] REG_RPM_PER_COUNT = 3'd0;
   localparam logic [2:0] REG_PROP_GAIN = 3'd1;
   localparam logic [2:0] REG_INTEG_GAIN_DT = 3'd2;
   localparam logic [2:0] REG_SLOW_RPM = 3'd3;
   localparam logic [2:0] REG_MID_RPM = 3'd4;
   localparam logic [2:0] REG_FAST_RPM = 3'd5;
   localparam logic [2:0] REG_WARN_LIMIT_RPM = 3'd6;
   localparam logic [2:0] REG_RAMP_STEP = 3'd7;

   localparam logic [15:0] RST_RPM_PER_COUNT = 16'd29789;
   localparam logic [15:0] RST_PROP_GAIN = 16'd22938;
   localparam logic [15:0] RST_INTEG_GAIN_DT = 16'd2621;
   localparam logic [15:0] RST_SLOW_RPM = 16'd20480;
   localparam logic [15:0] RST_MID_RPM = 16'd30720;
   localparam logic [15:0] RST_FAST_RPM = 16'd38400;
   localparam logic [15:0] RST_WARN_LIMIT_RPM = 16'd7680;
   localparam logic [15:0] RST_RAMP_STEP = 16'd512;

   localparam logic [14:0] DUTY_FULL = 15'd25600;
   localparam logic signed [16:0] RECOVER_TOL_HI = 17'sd25;
   localparam logic signed [16:0] RECOVER_TOL_LO = -17'sd25;

   // Reciprocal of 100 scaled by 2**30, rounded up; exact for the quotient range used.
   localparam logic [24:0] QUOT_RECIP = 25'd10737419;

   typedef logic signed [25:0] mul_a_type;
   typedef logic signed [24:0] mul_b_type;
   typedef logic signed [50:0] prod_type;
   typedef logic signed [41:0] acc_type;
   typedef logic signed [22:0] speed_type;
   typedef logic signed [23:0] err_type;
   typedef logic signed [24:0] diff_type;

   typedef struct packed {
      mul_a_type a;
      mul_b_type b;
   } mul_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPEED_MUL,
      ST_SPEED,
      ST_RAMP,
      ST_ERR,
      ST_INTEG_MUL,
      ST_PROP_MUL,
      ST_ACC,
      ST_DUTY,
      ST_PWM_MUL,
      ST_QUOT_MUL,
      ST_PWM,
      ST_RESP
   } state_type;

endpackage

### hw/rtl/espr_req_if.sv
interface espr_req_if;
   logic valid;
   logic ready;
   logic [2:0] op;
   logic [15:0] encoder_count;
   logic [1:0] level_req;

   modport source (output valid, output op, output encoder_count, output level_req,
                   input ready);
   modport sink (input valid, input op, input encoder_count, input level_req,
                 output ready);
endinterface

### hw/rtl/espr_rsp_if.sv
interface espr_rsp_if;
   logic valid;
   logic ready;
   logic running;
   logic [1:0] level_now;
   logic [15:0] target_speed;
   logic signed [22:0] measured_speed;
   logic [14:0] duty_pct;
   logic [5:0] pwm_compare;
   logic slowdown_on;
   logic recovering;

   modport source (output valid, output running, output level_now, output target_speed,
                   output measured_speed, output duty_pct, output pwm_compare,
                   output slowdown_on, output recovering, input ready);
   modport sink (input valid, input running, input level_now, input target_speed,
                 input measured_speed, input duty_pct, input pwm_compare,
                 input slowdown_on, input recovering, output ready);
endinterface

### hw/rtl/espr_mul.sv
module espr_mul (
   input  logic                   clock,
   input  espr_pkg::mul_req_type  mul_req,
   output espr_pkg::prod_type     prod
);

   espr_pkg::prod_type prod_in;
   espr_pkg::prod_type prod_ff;

   assign prod_in = $signed(mul_req.a) * $signed(mul_req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### hw/rtl/encoder_speed_pi_with_ramp.sv
// Encoder speed controller with target ramp and velocity-form PI loop.
// The req_chan channel carries one command per transaction: tick (with the
// encoder count), start, stop, set level, warning slowdown or warning recover.
// Every command yields exactly one status transaction on rsp_chan.
// Gains, count scale, level speeds, warning limit and ramp step are written
// through the csr_ port; the user must write them only while the block is
// idle, as the block itself does not enforce it; writes take effect at once.
// All products share one registered multiplier under a small sequencer.
// A tick while running works through speed, ramp, error, two PI products,
// duty and two products for the PWM compare before its status is valid; a
// tick while stopped works through the speed product and speed only;
// every other command shows its status in the cycle after acceptance.
// The block takes one command at a time; req_chan.ready returns in the cycle
// after the status transaction completes.
// While rsp_chan.ready is low the status holds and no command is taken.
// Synchronous reset restores the register defaults, stops the motor and
// clears the count history, speed and PI state.
module encoder_speed_pi_with_ramp #(
   parameter int unsigned PWM_PERIOD = 50
) (
   input  logic                          clock,
   input  logic                          reset,
   espr_req_if.sink                      req_chan,
   espr_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [espr_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [espr_pkg::CFG_W-1:0]    csr_wdata
);

   localparam espr_pkg::mul_a_type PERIOD_OP = espr_pkg::mul_a_type'(PWM_PERIOD);

   espr_pkg::state_type state_ff, state_in;

   logic [15:0] rpm_per_count_ff, prop_gain_ff, integ_gain_dt_ff;
   logic [15:0] slow_rpm_ff, mid_rpm_ff, fast_rpm_ff, warn_limit_rpm_ff, ramp_step_ff;

   logic [15:0] last_count_ff, last_count_in;
   logic run_flag_ff, run_flag_in;
   logic [1:0] level_ff, level_in;
   logic [15:0] user_speed_ff, user_speed_in;
   logic [15:0] ramp_target_ff, ramp_target_in;
   espr_pkg::speed_type speed_meas_ff, speed_meas_in;
   logic slow_flag_ff, slow_flag_in;
   logic recover_flag_ff, recover_flag_in;
   espr_pkg::err_type last_error_ff, last_error_in;
   logic [14:0] last_duty_ff, last_duty_in;
   logic [14:0] duty_now_ff, duty_now_in;
   logic [5:0] pwm_ff, pwm_in;

   logic signed [15:0] delta_ff, delta_in;
   espr_pkg::err_type err_ff, err_in;
   espr_pkg::diff_type diff_ff, diff_in;
   espr_pkg::acc_type acc_ff, acc_in;

   espr_pkg::mul_req_type mul_req;
   espr_pkg::prod_type prod;

   logic req_accept;
   logic [15:0] level_speed;
   logic signed [24:0] speed_full;
   logic [15:0] desired;
   logic [16:0] ramp_up;
   logic [16:0] ramp_dn;
   logic signed [16:0] recover_diff;
   logic signed [25:0] duty_inc;
   logic signed [26:0] duty_sum;

   espr_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == espr_pkg::ST_IDLE);

   assign rsp_chan.valid = (state_ff == espr_pkg::ST_RESP);
   assign rsp_chan.running = run_flag_ff;
   assign rsp_chan.level_now = level_ff;
   assign rsp_chan.target_speed = ramp_target_ff;
   assign rsp_chan.measured_speed = speed_meas_ff;
   assign rsp_chan.duty_pct = duty_now_ff;
   assign rsp_chan.pwm_compare = pwm_ff;
   assign rsp_chan.slowdown_on = slow_flag_ff;
   assign rsp_chan.recovering = recover_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_per_count_ff <= espr_pkg::RST_RPM_PER_COUNT;
         prop_gain_ff <= espr_pkg::RST_PROP_GAIN;
         integ_gain_dt_ff <= espr_pkg::RST_INTEG_GAIN_DT;
         slow_rpm_ff <= espr_pkg::RST_SLOW_RPM;
         mid_rpm_ff <= espr_pkg::RST_MID_RPM;
         fast_rpm_ff <= espr_pkg::RST_FAST_RPM;
         warn_limit_rpm_ff <= espr_pkg::RST_WARN_LIMIT_RPM;
         ramp_step_ff <= espr_pkg::RST_RAMP_STEP;
      end else if (csr_we) begin
         case (csr_index)
            espr_pkg::REG_RPM_PER_COUNT: rpm_per_count_ff <= csr_wdata;
            espr_pkg::REG_PROP_GAIN: prop_gain_ff <= csr_wdata;
            espr_pkg::REG_INTEG_GAIN_DT: integ_gain_dt_ff <= csr_wdata;
            espr_pkg::REG_SLOW_RPM: slow_rpm_ff <= csr_wdata;
            espr_pkg::REG_MID_RPM: mid_rpm_ff <= csr_wdata;
            espr_pkg::REG_FAST_RPM: fast_rpm_ff <= csr_wdata;
            espr_pkg::REG_WARN_LIMIT_RPM: warn_limit_rpm_ff <= csr_wdata;
            espr_pkg::REG_RAMP_STEP: ramp_step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= espr_pkg::ST_IDLE;
         last_count_ff <= '0;
         run_flag_ff <= 1'b0;
         level_ff <= espr_pkg::LVL_STOP;
         user_speed_ff <= '0;
         ramp_target_ff <= '0;
         speed_meas_ff <= '0;
         slow_flag_ff <= 1'b0;
         recover_flag_ff <= 1'b0;
         last_error_ff <= '0;
         last_duty_ff <= '0;
         duty_now_ff <= '0;
         pwm_ff <= '0;
      end else begin
         state_ff <= state_in;
         last_count_ff <= last_count_in;
         run_flag_ff <= run_flag_in;
         level_ff <= level_in;
         user_speed_ff <= user_speed_in;
         ramp_target_ff <= ramp_target_in;
         speed_meas_ff <= speed_meas_in;
         slow_flag_ff <= slow_flag_in;
         recover_flag_ff <= recover_flag_in;
         last_error_ff <= last_error_in;
         last_duty_ff <= last_duty_in;
         duty_now_ff <= duty_now_in;
         pwm_ff <= pwm_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      err_ff <= err_in;
      diff_ff <= diff_in;
      acc_ff <= acc_in;
   end

   always_comb begin
      case (req_chan.level_req)
         espr_pkg::LVL_SLOW: level_speed = slow_rpm_ff;
         espr_pkg::LVL_MID: level_speed = mid_rpm_ff;
         default: level_speed = fast_rpm_ff;
      endcase
   end

   assign speed_full = prod[32:8];
   assign desired = slow_flag_ff ? warn_limit_rpm_ff : user_speed_ff;
   assign ramp_up = {1'b0, ramp_target_ff} + {1'b0, ramp_step_ff};
   assign ramp_dn = {1'b0, ramp_target_ff} - {1'b0, ramp_step_ff};
   assign recover_diff = $signed({1'b0, ramp_target_ff}) - $signed({1'b0, user_speed_ff});
   assign duty_inc = acc_ff[41:16];
   assign duty_sum = $signed({12'b0, last_duty_ff}) + 27'(duty_inc);

   always_comb begin
      state_in = state_ff;
      last_count_in = last_count_ff;
      run_flag_in = run_flag_ff;
      level_in = level_ff;
      user_speed_in = user_speed_ff;
      ramp_target_in = ramp_target_ff;
      speed_meas_in = speed_meas_ff;
      slow_flag_in = slow_flag_ff;
      recover_flag_in = recover_flag_ff;
      last_error_in = last_error_ff;
      last_duty_in = last_duty_ff;
      duty_now_in = duty_now_ff;
      pwm_in = pwm_ff;
      delta_in = delta_ff;
      err_in = err_ff;
      diff_in = diff_ff;
      acc_in = acc_ff;
      mul_req.a = '0;
      mul_req.b = '0;

      case (state_ff)
         espr_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = espr_pkg::ST_RESP;
               case (req_chan.op)
                  espr_pkg::OP_TICK: begin
                     delta_in = $signed(req_chan.encoder_count - last_count_ff);
                     last_count_in = req_chan.encoder_count;
                     state_in = espr_pkg::ST_SPEED_MUL;
                  end
                  espr_pkg::OP_START: begin
                     run_flag_in = 1'b1;
                     level_in = espr_pkg::LVL_MID;
                     user_speed_in = mid_rpm_ff;
                     ramp_target_in = mid_rpm_ff;
                     slow_flag_in = 1'b0;
                     recover_flag_in = 1'b0;
                     last_error_in = '0;
                     last_duty_in = '0;
                     duty_now_in = '0;
                     pwm_in = '0;
                  end
                  espr_pkg::OP_STOP, espr_pkg::OP_SET_LEVEL: begin
                     if (req_chan.op == espr_pkg::OP_SET_LEVEL &&
                         req_chan.level_req != espr_pkg::LVL_STOP) begin
                        level_in = req_chan.level_req;
                        user_speed_in = level_speed;
                        if (!slow_flag_ff) begin
                           ramp_target_in = level_speed;
                        end
                     end else begin
                        run_flag_in = 1'b0;
                        level_in = espr_pkg::LVL_STOP;
                        user_speed_in = '0;
                        ramp_target_in = '0;
                        slow_flag_in = 1'b0;
                        recover_flag_in = 1'b0;
                        last_error_in = '0;
                        last_duty_in = '0;
                        duty_now_in = '0;
                        pwm_in = '0;
                     end
                  end
                  espr_pkg::OP_WARN_SLOW: begin
                     if (run_flag_ff) begin
                        slow_flag_in = 1'b1;
                        recover_flag_in = 1'b0;
                     end
                  end
                  espr_pkg::OP_WARN_RECOVER: begin
                     slow_flag_in = 1'b0;
                     recover_flag_in = run_flag_ff;
                  end
                  default: ;
               endcase
            end
         end
         espr_pkg::ST_SPEED_MUL: begin
            mul_req.a = espr_pkg::mul_a_type'(delta_ff);
            mul_req.b = espr_pkg::mul_b_type'(rpm_per_count_ff);
            state_in = espr_pkg::ST_SPEED;
         end
         espr_pkg::ST_SPEED: begin
            if (speed_full[24:22] == 3'b000 || speed_full[24:22] == 3'b111) begin
               speed_meas_in = speed_full[22:0];
            end else if (speed_full[24]) begin
               speed_meas_in = {1'b1, 22'b0};
            end else begin
               speed_meas_in = {1'b0, {22{1'b1}}};
            end
            if (run_flag_ff) begin
               state_in = espr_pkg::ST_RAMP;
            end else begin
               duty_now_in = '0;
               pwm_in = '0;
               state_in = espr_pkg::ST_RESP;
            end
         end
         espr_pkg::ST_RAMP: begin
            if (ramp_target_ff < desired) begin
               ramp_target_in = (ramp_up > {1'b0, desired}) ? desired : ramp_up[15:0];
            end else if (ramp_target_ff > desired) begin
               ramp_target_in = (ramp_dn[16] || ramp_dn[15:0] < desired) ?
                                desired : ramp_dn[15:0];
            end
            state_in = espr_pkg::ST_ERR;
         end
         espr_pkg::ST_ERR: begin
            err_in = espr_pkg::err_type'({1'b0, ramp_target_ff}) -
                     espr_pkg::err_type'(speed_meas_ff);
            if (recover_flag_ff && recover_diff >= espr_pkg::RECOVER_TOL_LO &&
                recover_diff <= espr_pkg::RECOVER_TOL_HI) begin
               recover_flag_in = 1'b0;
            end
            state_in = espr_pkg::ST_INTEG_MUL;
         end
         espr_pkg::ST_INTEG_MUL: begin
            mul_req.a = espr_pkg::mul_a_type'(err_ff);
            mul_req.b = espr_pkg::mul_b_type'(integ_gain_dt_ff);
            diff_in = espr_pkg::diff_type'(err_ff) - espr_pkg::diff_type'(last_error_ff);
            state_in = espr_pkg::ST_PROP_MUL;
         end
         espr_pkg::ST_PROP_MUL: begin
            mul_req.a = espr_pkg::mul_a_type'(diff_ff);
            mul_req.b = espr_pkg::mul_b_type'(prop_gain_ff);
            acc_in = espr_pkg::acc_type'(prod);
            state_in = espr_pkg::ST_ACC;
         end
         espr_pkg::ST_ACC: begin
            acc_in = acc_ff + espr_pkg::acc_type'(prod);
            state_in = espr_pkg::ST_DUTY;
         end
         espr_pkg::ST_DUTY: begin
            if (duty_sum[26]) begin
               duty_now_in = '0;
            end else if (duty_sum[25:0] > 26'(espr_pkg::DUTY_FULL)) begin
               duty_now_in = espr_pkg::DUTY_FULL;
            end else begin
               duty_now_in = duty_sum[14:0];
            end
            last_duty_in = duty_now_in;
            last_error_in = err_ff;
            state_in = espr_pkg::ST_PWM_MUL;
         end
         espr_pkg::ST_PWM_MUL: begin
            mul_req.a = PERIOD_OP;
            mul_req.b = espr_pkg::mul_b_type'(duty_now_ff);
            state_in = espr_pkg::ST_QUOT_MUL;
         end
         espr_pkg::ST_QUOT_MUL: begin
            mul_req.a = espr_pkg::mul_a_type'(prod[30:8]);
            mul_req.b = espr_pkg::QUOT_RECIP;
            state_in = espr_pkg::ST_PWM;
         end
         espr_pkg::ST_PWM: begin
            pwm_in = prod[35:30];
            state_in = espr_pkg::ST_RESP;
         end
         espr_pkg::ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = espr_pkg::ST_IDLE;
            end
         end
         default: state_in = espr_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_now_ff <= espr_pkg::DUTY_FULL)
      else $error("duty above full scale");

   a_stopped_no_duty: assert property (@(posedge clock) disable iff (reset)
      !run_flag_ff |-> duty_now_ff == '0)
      else $error("nonzero duty while stopped");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("command taken while a status is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("ready right after a transaction");

   a_pwm_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && duty_now_ff == '0 |-> pwm_ff == '0)
      else $error("compare value nonzero at zero duty");
`endif

endmodule

### bench/tb_encoder_speed_pi_with_ramp.sv
module tb_encoder_speed_pi_with_ramp;
   timeunit 1ns;
   timeprecision 1ps;

   import espr_pkg::*;

   localparam int unsigned PWM_PERIOD = 50;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] count;
      logic [1:0]  level;
   } command_type;

   typedef struct packed {
      logic        running;
      logic [1:0]  level;
      logic [15:0] target;
      speed_type   speed;
      logic [14:0] duty;
      logic [5:0]  pwm;
      logic        slow;
      logic        recover;
   } status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;
   logic rsp_hold = 1'b0;

   espr_req_if req_chan();
   espr_rsp_if rsp_chan();

   encoder_speed_pi_with_ramp #(.PWM_PERIOD(PWM_PERIOD)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   command_type cmd_q[$];
   status_type status_q[$];

   // Shadow of the controller registers and state.
   logic [15:0] cfg_reg [8];
   logic [15:0] m_last_count;
   logic        m_run;
   logic [1:0]  m_level;
   logic [15:0] m_user;
   logic [15:0] m_target;
   speed_type   m_speed;
   logic        m_slow;
   logic        m_recover;
   err_type     m_last_err;
   logic [14:0] m_last_duty;
   logic [14:0] m_duty;

   logic [15:0] enc_pos = 16'd0;
   bit drv_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int send_gap = 0;
   int rsp_gap = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int n_profiles = 0;
   int fail_count = 0;
   int shown = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_motion();
      m_run = 1'b0;
      m_level = LVL_STOP;
      m_user = '0;
      m_target = '0;
      m_slow = 1'b0;
      m_recover = 1'b0;
      m_last_err = '0;
      m_last_duty = '0;
      m_duty = '0;
   endfunction

   function automatic status_type apply_command(command_type c);
      status_type s;
      logic [15:0] diff;
      longint delta, spd, want, t, e, acc, nd;
      case (c.op)
         OP_TICK: begin
            diff = c.count - m_last_count;
            m_last_count = c.count;
            delta = longint'(diff);
            if (diff[15])
               delta -= 65536;
            spd = (delta * longint'(cfg_reg[REG_RPM_PER_COUNT])) >>> 8;
            if (spd > 4194303)
               spd = 4194303;
            if (spd < -4194304)
               spd = -4194304;
            m_speed = speed_type'(spd);
            if (m_run) begin
               want = m_slow ? longint'(cfg_reg[REG_WARN_LIMIT_RPM]) : longint'(m_user);
               t = longint'(m_target);
               if (t < want) begin
                  t += longint'(cfg_reg[REG_RAMP_STEP]);
                  if (t > want)
                     t = want;
               end else if (t > want) begin
                  t -= longint'(cfg_reg[REG_RAMP_STEP]);
                  if (t < want)
                     t = want;
               end
               m_target = 16'(t);
               if (m_recover && (t - longint'(m_user)) >= RECOVER_TOL_LO
                   && (t - longint'(m_user)) <= RECOVER_TOL_HI)
                  m_recover = 1'b0;
               e = longint'(m_target) - longint'(m_speed);
               acc = longint'(cfg_reg[REG_PROP_GAIN]) * (e - longint'(m_last_err))
                     + longint'(cfg_reg[REG_INTEG_GAIN_DT]) * e;
               nd = longint'(m_last_duty) + (acc >>> 16);
               if (nd > longint'(DUTY_FULL))
                  nd = longint'(DUTY_FULL);
               if (nd < 0)
                  nd = 0;
               m_duty = 15'(nd);
               m_last_duty = m_duty;
               m_last_err = err_type'(e);
            end else begin
               m_duty = '0;
            end
         end
         OP_START: begin
            clear_motion();
            m_run = 1'b1;
            m_level = LVL_MID;
            m_user = cfg_reg[REG_MID_RPM];
            m_target = m_user;
         end
         OP_STOP: clear_motion();
         OP_SET_LEVEL: begin
            if (c.level == LVL_STOP) begin
               clear_motion();
            end else begin
               m_level = c.level;
               case (c.level)
                  LVL_SLOW: m_user = cfg_reg[REG_SLOW_RPM];
                  LVL_MID: m_user = cfg_reg[REG_MID_RPM];
                  default: m_user = cfg_reg[REG_FAST_RPM];
               endcase
               if (!m_slow)
                  m_target = m_user;
            end
         end
         OP_WARN_SLOW: begin
            if (m_run) begin
               m_slow = 1'b1;
               m_recover = 1'b0;
            end
         end
         OP_WARN_RECOVER: begin
            m_slow = 1'b0;
            m_recover = m_run;
         end
         default: ;
      endcase
      s.running = m_run;
      s.level = m_level;
      s.target = m_target;
      s.speed = m_speed;
      s.duty = m_duty;
      s.pwm = 6'((longint'(PWM_PERIOD) * longint'(m_duty)) / longint'(DUTY_FULL));
      s.slow = m_slow;
      s.recover = m_recover;
      return s;
   endfunction

   function automatic string fmt_status(status_type s);
      return $sformatf("run=%0b lvl=%0d tgt=%0d spd=%0d duty=%0d pwm=%0d slow=%0b rec=%0b",
                       s.running, s.level, s.target, s.speed, s.duty, s.pwm, s.slow,
                       s.recover);
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   always @(posedge clock) begin : drive
      command_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.op <= OP_TICK;
         req_chan.encoder_count <= '0;
         req_chan.level_req <= LVL_STOP;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            status_q.push_back(apply_command('{op: req_chan.op,
                                               count: req_chan.encoder_count,
                                               level: req_chan.level_req}));
            n_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
               nxt = cmd_q.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.op <= nxt.op;
               req_chan.encoder_count <= nxt.count;
               req_chan.level_req <= nxt.level;
               send_gap = drv_idle_on ? pick_gap() : 0;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : observe
      status_type got, want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.running = rsp_chan.running;
            got.level = rsp_chan.level_now;
            got.target = rsp_chan.target_speed;
            got.speed = rsp_chan.measured_speed;
            got.duty = rsp_chan.duty_pct;
            got.pwm = rsp_chan.pwm_compare;
            got.slow = rsp_chan.slowdown_on;
            got.recover = rsp_chan.recovering;
            if (status_q.size() == 0) begin
               fail_count++;
               if (shown < 10) begin
                  shown++;
                  $display("Unexpected status transaction: %s", fmt_status(got));
               end
            end else begin
               want = status_q.pop_front();
               if (got.running !== want.running || got.level !== want.level
                   || got.target !== want.target || got.speed !== want.speed
                   || got.duty !== want.duty || got.pwm !== want.pwm
                   || got.slow !== want.slow || got.recover !== want.recover) begin
                  fail_count++;
                  if (shown < 10) begin
                     shown++;
                     $display("Mismatch on status transaction %0d", n_checked);
                     $display("  expected %s", fmt_status(want));
                     $display("  actual   %s", fmt_status(got));
                  end
               end
            end
            n_checked++;
         end
         if (rsp_hold) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            rsp_gap = rsp_idle_on ? pick_gap() : 0;
         end
      end
   end

   // The status channel stalls for a long stretch while commands keep coming,
   // so the block has to hold its status and push back on the command side.
   initial begin : backpressure
      wait (n_accepted >= 100);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic queue_cmd(input logic [2:0] op, input logic [15:0] cnt,
                            input logic [1:0] lvl);
      cmd_q.push_back('{op: op, count: cnt, level: lvl});
   endtask

   task automatic queue_tick(input logic [15:0] cnt);
      queue_cmd(OP_TICK, cnt, 2'($urandom));
   endtask

   task automatic queue_traffic(input int n);
      int k;
      int unsigned r;
      logic [2:0] nop;
      k = 0;
      while (k < n) begin
         if ($urandom_range(0, 99) < 75) begin
            queue_cmd(OP_START, 16'($urandom), 2'($urandom));
            k++;
            repeat ($urandom_range(4, 24)) begin
               r = $urandom_range(0, 99);
               if (r < 64) begin
                  enc_pos += 16'($urandom_range(0, 700));
                  queue_tick(enc_pos);
               end else if (r < 68) begin
                  enc_pos -= 16'($urandom_range(0, 300));
                  queue_tick(enc_pos);
               end else if (r < 71) begin
                  enc_pos = 16'($urandom);
                  queue_tick(enc_pos);
               end else if (r < 78) begin
                  queue_cmd(OP_SET_LEVEL, 16'($urandom), 2'($urandom_range(1, 3)));
               end else if (r < 86) begin
                  queue_cmd(OP_WARN_SLOW, 16'($urandom), 2'($urandom));
               end else if (r < 94) begin
                  queue_cmd(OP_WARN_RECOVER, 16'($urandom), 2'($urandom));
               end else if (r < 97) begin
                  queue_cmd(OP_SET_LEVEL, 16'($urandom), LVL_STOP);
               end else begin
                  queue_cmd(OP_STOP, 16'($urandom), 2'($urandom));
               end
               k++;
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               nop = 3'($urandom_range(0, 7));
               queue_cmd(nop, 16'($urandom), 2'($urandom));
               if (nop <= OP_WARN_RECOVER)
                  k++;
            end
         end
      end
   endtask

   task automatic settle();
      while (cmd_q.size() != 0 || req_chan.valid || status_q.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      cfg_reg[idx] = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_profile(input logic [15:0] vals [8], input bit drv_on,
                              input bit rsp_on, input int n);
      settle();
      for (int i = 0; i < 8; i++)
         write_csr(CFG_IDX_W'(i), vals[i]);
      @(negedge clock);
      drv_idle_on = drv_on;
      rsp_idle_on = rsp_on;
      queue_traffic(n);
      n_profiles++;
   endtask

   initial begin : stimulus
      logic [15:0] rnd [8];
      csr_we = 1'b0;
      csr_index = REG_RPM_PER_COUNT;
      csr_wdata = '0;
      cfg_reg = '{RST_RPM_PER_COUNT, RST_PROP_GAIN, RST_INTEG_GAIN_DT, RST_SLOW_RPM,
                  RST_MID_RPM, RST_FAST_RPM, RST_WARN_LIMIT_RPM, RST_RAMP_STEP};
      m_last_count = '0;
      m_speed = '0;
      clear_motion();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_tick(16'h0000);
      queue_tick(16'hFFFF);
      queue_cmd(3'd6, 16'hFFFF, LVL_FAST);
      queue_cmd(3'd7, 16'h0000, LVL_STOP);
      queue_cmd(OP_WARN_SLOW, 16'h0000, LVL_STOP);
      queue_cmd(OP_WARN_RECOVER, 16'h0000, LVL_STOP);
      queue_cmd(OP_SET_LEVEL, 16'h0000, LVL_FAST);
      queue_cmd(OP_SET_LEVEL, 16'h0000, LVL_SLOW);
      queue_cmd(OP_START, 16'h0000, LVL_STOP);
      queue_tick(16'h00FF);
      queue_tick(16'h01FF);
      queue_cmd(OP_SET_LEVEL, 16'h0000, LVL_FAST);
      queue_tick(16'h0300);
      queue_cmd(OP_WARN_SLOW, 16'h0000, LVL_STOP);
      queue_cmd(OP_SET_LEVEL, 16'h0000, LVL_SLOW);
      queue_tick(16'h0400);
      queue_tick(16'h0480);
      queue_cmd(OP_START, 16'h0000, LVL_STOP);
      queue_cmd(OP_WARN_SLOW, 16'h0000, LVL_STOP);
      queue_tick(16'h0580);
      queue_cmd(OP_WARN_RECOVER, 16'h0000, LVL_STOP);
      queue_tick(16'h0600);
      queue_tick(16'h8600);
      queue_tick(16'h05FF);
      queue_cmd(OP_SET_LEVEL, 16'h0000, LVL_STOP);
      queue_cmd(OP_STOP, 16'h0000, LVL_STOP);

      run_profile('{RST_RPM_PER_COUNT, RST_PROP_GAIN, RST_INTEG_GAIN_DT, RST_SLOW_RPM,
                    RST_MID_RPM, RST_FAST_RPM, RST_WARN_LIMIT_RPM, RST_RAMP_STEP},
                  1'b1, 1'b1, 130);
      run_profile('{default: 16'hFFFF}, 1'b0, 1'b0, 110);
      run_profile('{default: 16'h0000}, 1'b1, 1'b0, 110);
      // A fine ramp that lands exactly on the edge of the recovery window.
      run_profile('{RST_RPM_PER_COUNT, RST_PROP_GAIN, RST_INTEG_GAIN_DT, RST_SLOW_RPM,
                    RST_MID_RPM, RST_FAST_RPM, RST_MID_RPM - 16'd55, 16'd30},
                  1'b0, 1'b1, 110);
      repeat (2) begin
         foreach (rnd[i])
            rnd[i] = 16'($urandom_range(0, 65535));
         run_profile(rnd, 1'b1, 1'b1, 110);
      end

      settle();
      fail_count += status_q.size();
      $display("Sent %0d commands under %0d register profiles after the directed set.",
               n_accepted, n_profiles);
      $display("Checked %0d status transactions; %0d failed.", n_checked, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
